// ----- design/rpe_pkg.sv -----
// ----------------------------------------------------------------------------
// rpe_pkg
// Shared sizes and codes for the ranked-pairs election core.
// ----------------------------------------------------------------------------
package rpe_pkg;
	localparam int MaxCand   = 9;
	localparam int TallyW    = 16;
	localparam int CellCount = MaxCand * MaxCand;
	localparam int PairDepth = MaxCand * (MaxCand - 1) / 2;
	localparam int CandW     = 4;
	localparam int CellW     = $clog2(CellCount);
	localparam int PairIdxW  = $clog2(PairDepth + 1);
	localparam int PairWordW = 8 + TallyW;

	localparam logic [1:0] MODE_RANK   = 2'd0;
	localparam logic [1:0] MODE_DECIDE = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_WINNER  = 2'd2;
endpackage

// ----- design/ranked_pairs_election_core.sv -----
// ----------------------------------------------------------------------------
// ranked_pairs_election_core
// One item at a time: a rank entry, a recorded ballot, a clear or a decide (build
// the pairs, sort them, then lock and pick among n candidates) finishes with its
// result before the next item is taken; the single tally memory port and the pair
// memory's one read and one write port serialize the work.
// Reset clears control state, lock bits and pair count; count resets to 2; a
// sweep over all 81 tally cells then zeroes the tallies before the core is ready.
// ----------------------------------------------------------------------------
module ranked_pairs_election_core import rpe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // mode[1:0], rank_position[5:2], candidate_index[9:6], pad
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // status[1:0], winner[5:2], locked_count[11:6], pad
);
	localparam logic [4:0] S_IDLE = 5'd0, S_REC = 5'd1, S_CLR = 5'd2, S_BLD = 5'd3,
		S_SORT = 5'd4, S_LOCK = 5'd5, S_REACH = 5'd6, S_WIN = 5'd7, S_OUT = 5'd8,
		S_TRD = 5'd9, S_TWR = 5'd10, S_BRD = 5'd11, S_BCMP = 5'd12, S_INIT = 5'd13,
		S_SLD = 5'd14, S_SCMP = 5'd15, S_SPUT = 5'd16, S_LRD = 5'd17;

	logic [4:0] state_q;
	logic [3:0] count_q;
	logic [CandW-1:0] n_eff;
	logic [CandW-1:0] rank_buffer_q [MaxCand];
	logic [TallyW-1:0] tally_mem [CellCount];
	logic [TallyW-1:0] trd_q;
	logic [CellCount-1:0] lock_q;
	logic [PairWordW-1:0] pair_mem [PairDepth];
	logic [PairWordW-1:0] pr_q, hold_q;
	logic [7:0] cur_q;
	logic [PairIdxW-1:0] ptot_q;
	logic [CandW-1:0] a_q, b_q;
	logic [PairIdxW-1:0] p_q, q_q;
	logic [MaxCand-1:0] seen_q;
	logic grew_q;
	logic [CandW-1:0] u_q;
	logic [TallyW-1:0] ij_q;
	logic [5:0] locks_q;
	logic [CellW-1:0] clr_q;
	logic [15:0] out_q;
	logic [CellW-1:0] addr;
	logic [TallyW-1:0] wdata;
	logic wen;
	logic [PairIdxW-1:0] praddr, pwaddr;
	logic [PairWordW-1:0] pwdata;
	logic pwen;

	assign n_eff = (count_q < 4'd2) ? 4'd2 : (count_q > 4'(MaxCand)) ? 4'(MaxCand) : count_q;
	assign cfg_ready = (state_q == S_IDLE);
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = (state_q == S_OUT);
	assign m_tdata   = out_q;

	function automatic logic [CellW-1:0] cell_of(input logic [CandW-1:0] r,
		input logic [CandW-1:0] c);
		cell_of = CellW'(r * MaxCand + c);
	endfunction

	logic [TallyW-1:0] diff;
	assign diff = (ij_q > trd_q) ? ij_q - trd_q : trd_q - ij_q;

	// single tally memory port: address chosen per state
	always_comb begin
		addr  = cell_of(a_q, b_q);
		wen   = 1'b0;
		wdata = trd_q + 1'b1;
		case (state_q)
			S_CLR, S_INIT: begin addr = clr_q; wen = 1'b1; wdata = '0; end
			S_TWR: begin
				addr = cell_of(rank_buffer_q[a_q], rank_buffer_q[b_q]);
				wen = (trd_q != '1);
			end
			S_TRD: addr = cell_of(rank_buffer_q[a_q], rank_buffer_q[b_q]);
			S_BRD: addr = cell_of(a_q, b_q);
			S_BCMP: addr = cell_of(b_q, a_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wen) tally_mem[addr] <= wdata;
		trd_q <= tally_mem[addr];
	end

	// pair memory: one read and one write port; entry is {winner, loser, margin}
	always_comb begin
		praddr = p_q;
		pwaddr = q_q;
		pwen   = 1'b0;
		pwdata = hold_q;
		case (state_q)
			S_BLD: begin
				pwaddr = ptot_q;
				pwen   = (ij_q != trd_q);
				pwdata = {((ij_q > trd_q) ? {a_q, b_q} : {b_q, a_q}), diff};
			end
			S_SLD: praddr = q_q - 1'b1;
			S_SCMP: begin
				pwen = 1'b1;
				if (pr_q[TallyW-1:0] < hold_q[TallyW-1:0]) begin
					pwdata = pr_q;
					praddr = (q_q > PairIdxW'(1)) ? q_q - PairIdxW'(2) : '0;
				end
			end
			S_SPUT: pwen = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pwen) pair_mem[pwaddr] <= pwdata;
		pr_q <= pair_mem[praddr];
	end

	logic [CandW-1:0] cw, cl;
	logic [MaxCand-1:0] seen_nx;
	logic grow_nx;
	assign cw = cur_q[7:4];
	assign cl = cur_q[3:0];

	// one reachability pass step over row u
	always_comb begin
		seen_nx = seen_q;
		grow_nx = grew_q;
		if (seen_q[u_q]) begin
			for (int v = 0; v < MaxCand; v++) begin
				if (v < n_eff && !seen_q[v] && lock_q[cell_of(u_q, CandW'(v))]) begin
					seen_nx[v] = 1'b1;
					grow_nx = 1'b1;
				end
			end
		end
	end

	logic [CandW-1:0] win_idx;
	always_comb begin
		win_idx = '0;
		for (int l = MaxCand - 1; l >= 0; l--) begin
			logic beaten;
			beaten = 1'b0;
			for (int w = 0; w < MaxCand; w++)
				if (lock_q[w * MaxCand + l]) beaten = 1'b1;
			if (l < n_eff && !beaten) win_idx = CandW'(l);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			count_q <= 4'd2;
			lock_q  <= '0;
			ptot_q  <= '0;
			clr_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cfg_valid) count_q <= cfg_data;
					if (s_tvalid) begin
						out_q <= (s_tdata[1:0] == MODE_RANK && s_tdata[9:6] >= n_eff) ?
							{14'd0, ST_INVALID} : 16'd0;
						a_q <= '0;
						b_q <= 4'd1;
						case (s_tdata[1:0])
							MODE_RANK: begin
								if (s_tdata[9:6] >= n_eff) begin
									state_q <= S_OUT;
								end else begin
									if (s_tdata[5:2] < n_eff)
										rank_buffer_q[s_tdata[5:2]] <= s_tdata[9:6];
									state_q <= s_tlast ? S_TRD : S_OUT;
								end
							end
							MODE_DECIDE: begin
								lock_q <= '0;
								ptot_q <= '0;
								locks_q <= '0;
								state_q <= S_BRD;
							end
							MODE_CLEAR: begin
								lock_q <= '0;
								ptot_q <= '0;
								clr_q <= '0;
								state_q <= S_CLR;
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_CLR, S_INIT: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CellW'(CellCount - 1))
						state_q <= (state_q == S_INIT) ? S_IDLE : S_OUT;
				end
				S_TRD: state_q <= S_TWR;
				S_TWR: begin
					if (b_q + 1'b1 < n_eff) begin
						b_q <= b_q + 1'b1;
						state_q <= S_TRD;
					end else if (a_q + 4'd2 < n_eff) begin
						a_q <= a_q + 1'b1;
						b_q <= a_q + 4'd2;
						state_q <= S_TRD;
					end else state_q <= S_OUT;
				end
				S_BRD: state_q <= S_BCMP;
				S_BCMP: begin
					// trd_q holds [a][b] now; ij captured next
					ij_q <= trd_q;
					state_q <= S_BLD;
				end
				S_BLD: begin
					if (ij_q != trd_q) ptot_q <= ptot_q + 1'b1;
					if (b_q + 1'b1 < n_eff) begin
						b_q <= b_q + 1'b1;
						state_q <= S_BRD;
					end else if (a_q + 4'd2 < n_eff) begin
						a_q <= a_q + 1'b1;
						b_q <= a_q + 4'd2;
						state_q <= S_BRD;
					end else begin
						p_q <= PairIdxW'(1);
						state_q <= S_SORT;
					end
				end
				S_SORT: begin
					// insertion: hold entry p, shift larger-margin-first down to its slot
					if (p_q >= ptot_q) begin
						p_q <= '0;
						state_q <= S_LOCK;
					end else begin
						q_q <= p_q;
						state_q <= S_SLD;
					end
				end
				S_SLD: begin
					hold_q <= pr_q;
					state_q <= S_SCMP;
				end
				S_SCMP: begin
					if (pr_q[TallyW-1:0] < hold_q[TallyW-1:0]) begin
						q_q <= q_q - 1'b1;
						if (q_q == PairIdxW'(1)) state_q <= S_SPUT;
					end else begin
						p_q <= p_q + 1'b1;
						state_q <= S_SORT;
					end
				end
				S_SPUT: begin
					p_q <= p_q + 1'b1;
					state_q <= S_SORT;
				end
				S_LOCK: begin
					if (p_q >= ptot_q) state_q <= S_WIN;
					else state_q <= S_LRD;
				end
				S_LRD: begin
					cur_q <= pr_q[PairWordW-1:TallyW];
					seen_q <= MaxCand'(1) << pr_q[TallyW+3:TallyW];
					grew_q <= 1'b0;
					u_q <= '0;
					state_q <= S_REACH;
				end
				S_REACH: begin
					seen_q <= seen_nx;
					if (u_q + 1'b1 < n_eff) begin
						u_q <= u_q + 1'b1;
						grew_q <= grow_nx;
					end else begin
						u_q <= '0;
						grew_q <= 1'b0;
						if (!grow_nx) begin
							if (!seen_nx[cw]) begin
								lock_q[cell_of(cw, cl)] <= 1'b1;
								locks_q <= locks_q + 1'b1;
							end
							p_q <= p_q + 1'b1;
							state_q <= S_LOCK;
						end
					end
				end
				S_WIN: begin
					out_q <= {4'd0, locks_q, win_idx, ST_WINNER};
					state_q <= S_OUT;
				end
				S_OUT: if (m_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_tready)
		else $error("accepting while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result dropped");
	a_lock_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WIN) |-> (locks_q <= 6'(ptot_q)))
		else $error("more locks than pairs");
endmodule

// ----- verif/ranked_pairs_election_checker.sv -----
// ----------------------------------------------------------------------------
// ranked_pairs_election_checker
// Watches the configuration, ballot and result channels of the election core,
// keeps its own copy of the tallies and locks, works out the result of every
// accepted beat and compares it field by field with what the core returns.
// ----------------------------------------------------------------------------
module ranked_pairs_election_checker import rpe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,  // mode[1:0], rank_position[5:2], candidate_index[9:6], pad
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,  // status[1:0], winner[5:2], locked_count[11:6], pad
	output int          failures,
	output int          pending,
	output int          results
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] winner;
		logic [5:0] locked_count;
	} outcome_t;

	outcome_t    outcome_q[$];
	logic [3:0]  ballot[MaxCand];
	logic [15:0] tally[MaxCand][MaxCand];
	bit          locked[MaxCand][MaxCand];
	logic [3:0]  cand_count;

	function automatic int field_count();
		if (cand_count < 2) return 2;
		if (cand_count > MaxCand) return MaxCand;
		return int'(cand_count);
	endfunction

	function automatic bit has_path(int src, int dst, int n);
		bit seen[MaxCand];
		bit grew;
		grew = 1'b1;
		foreach (seen[k]) seen[k] = 1'b0;
		seen[src] = 1'b1;
		while (grew) begin
			grew = 1'b0;
			for (int u = 0; u < n; u++) begin
				if (!seen[u]) continue;
				for (int v = 0; v < n; v++) begin
					if (!seen[v] && locked[u][v]) begin
						seen[v] = 1'b1;
						grew = 1'b1;
					end
				end
			end
		end
		return seen[dst];
	endfunction

	// Build majority pairs, stable sort by falling margin, lock acyclically.
	function automatic outcome_t elect(int n);
		outcome_t   r;
		logic [3:0] win_of[PairDepth];
		logic [3:0] lose_of[PairDepth];
		logic [15:0] margin[PairDepth];
		logic [3:0] tw, tl;
		logic [15:0] tm;
		int total, q;
		bit beaten;
		r = '0;
		total = 0;
		foreach (locked[a, b]) locked[a][b] = 1'b0;
		for (int i = 0; i < n - 1; i++) begin
			for (int j = i + 1; j < n; j++) begin
				if (tally[i][j] == tally[j][i]) continue;
				if (tally[i][j] > tally[j][i]) begin
					win_of[total] = 4'(i);
					lose_of[total] = 4'(j);
					margin[total] = tally[i][j] - tally[j][i];
				end else begin
					win_of[total] = 4'(j);
					lose_of[total] = 4'(i);
					margin[total] = tally[j][i] - tally[i][j];
				end
				total++;
			end
		end
		for (int p = 1; p < total; p++) begin
			tw = win_of[p];
			tl = lose_of[p];
			tm = margin[p];
			q = p;
			while (q > 0 && margin[q - 1] < tm) begin
				win_of[q] = win_of[q - 1];
				lose_of[q] = lose_of[q - 1];
				margin[q] = margin[q - 1];
				q--;
			end
			win_of[q] = tw;
			lose_of[q] = tl;
			margin[q] = tm;
		end
		for (int p = 0; p < total; p++) begin
			if (!has_path(int'(lose_of[p]), int'(win_of[p]), n)) begin
				locked[win_of[p]][lose_of[p]] = 1'b1;
				r.locked_count++;
			end
		end
		r.status = ST_WINNER;
		for (int l = n - 1; l >= 0; l--) begin
			beaten = 1'b0;
			for (int w = 0; w < n; w++) if (locked[w][l]) beaten = 1'b1;
			if (!beaten) r.winner = 4'(l);
		end
		return r;
	endfunction

	function automatic outcome_t tally_beat(logic [1:0] mode, logic [3:0] pos,
		logic [3:0] cand, logic last);
		outcome_t r;
		int n;
		r = '0;
		n = field_count();
		case (mode)
			MODE_RANK: begin
				if (cand >= n) begin
					r.status = ST_INVALID;
				end else begin
					if (pos < n) ballot[pos] = cand;
					if (last) begin
						for (int a = 0; a < n - 1; a++)
							for (int b = a + 1; b < n; b++)
								if (tally[ballot[a]][ballot[b]] != '1)
									tally[ballot[a]][ballot[b]]++;
					end
				end
			end
			MODE_DECIDE: r = elect(n);
			MODE_CLEAR: begin
				foreach (tally[a, b]) tally[a][b] = '0;
				foreach (locked[a, b]) locked[a][b] = 1'b0;
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t seen_r, want;
		if (!arst_n) begin
			outcome_q.delete();
			foreach (tally[a, b]) tally[a][b] = '0;
			foreach (locked[a, b]) locked[a][b] = 1'b0;
			foreach (ballot[k]) ballot[k] = '0;
			cand_count = 4'd2;
			failures = 0;
			pending = 0;
			results = 0;
		end else begin
			if (cfg_valid && cfg_ready) cand_count = cfg_data;
			if (s_tvalid && s_tready)
				outcome_q.push_back(tally_beat(s_tdata[1:0], s_tdata[5:2], s_tdata[9:6],
					s_tlast));
			if (m_tvalid && m_tready) begin
				results++;
				seen_r = {m_tdata[1:0], m_tdata[5:2], m_tdata[11:6]};
				if (outcome_q.size() == 0) begin
					$error("result beat with nothing outstanding: %h", m_tdata);
					failures++;
				end else begin
					want = outcome_q.pop_front();
					if (seen_r.status != want.status) begin
						$error("status: expected %0d, got %0d", want.status, seen_r.status);
						failures++;
					end
					if (seen_r.winner != want.winner) begin
						$error("winner: expected %0d, got %0d", want.winner, seen_r.winner);
						failures++;
					end
					if (seen_r.locked_count != want.locked_count) begin
						$error("locked_count: expected %0d, got %0d", want.locked_count,
							seen_r.locked_count);
						failures++;
					end
				end
			end
			pending = outcome_q.size();
		end
	end
endmodule

// ----- verif/ranked_pairs_election_core_tb.sv -----
// ----------------------------------------------------------------------------
// ranked_pairs_election_core_tb
// Drives ballots, decides and clears into the election core over several
// candidate counts, with random gaps and back-pressure; the checker beside
// the core predicts and compares every result.
// ----------------------------------------------------------------------------
module ranked_pairs_election_core_tb import rpe_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QuietLimit = 150000;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;  // mode[1:0], rank_position[5:2], candidate_index[9:6], pad
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;  // status[1:0], winner[5:2], locked_count[11:6], pad
	int          failures, pending, results;
	int          beats_sent, settings_run, quiet, sink_hold;
	bit          no_gaps;

	ranked_pairs_election_core u_top (.*);

	ranked_pairs_election_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result sink: random hold-off after each beat, none while no_gaps is set.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_hold = 0;
		end else if (m_tready) begin
			if (m_tvalid) begin
				sink_hold = no_gaps ? 0 : $urandom_range(0, 17);
				if (sink_hold != 0) m_tready <= 1'b0;
			end
		end else begin
			if (sink_hold <= 1) m_tready <= 1'b1;
			sink_hold--;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			(cfg_valid && cfg_ready) || (pending == 0 && !s_tvalid)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QuietLimit) begin
				$display("[ranked_pairs_election_core] ERROR");
				$finish;
			end
		end
	end

	function automatic int field_count(logic [3:0] c);
		if (c < 2) return 2;
		if (c > MaxCand) return MaxCand;
		return int'(c);
	endfunction

	// Drop the last beat so it is not taken twice, then wait for every result.
	task automatic drain();
		if (s_tvalid) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		while (pending != 0 || s_tvalid) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic send_beat(logic [1:0] mode, logic [3:0] pos, logic [3:0] cand, logic last);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, cand, pos, mode};
		s_tlast <= last;
		forever begin
			@(negedge clk);
			if (s_tready) break;
		end
		@(posedge clk);
		beats_sent++;
	endtask

	task automatic set_count(logic [3:0] c);
		if (s_tvalid) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= c;
		forever begin
			@(negedge clk);
			if (cfg_ready) break;
		end
		@(posedge clk);
		cfg_valid <= 1'b0;
		settings_run++;
	endtask

	// One ballot: a shuffled ranking, now and then with a repeat or a
	// stray invalid beat, positions sent in random order.
	task automatic cast_ballot(int n);
		logic [3:0] pick[MaxCand];
		int order[MaxCand];
		int k, t;
		for (k = 0; k < n; k++) begin
			pick[k] = 4'(k);
			order[k] = k;
		end
		for (k = n - 1; k > 0; k--) begin
			t = $urandom_range(0, k);
			{pick[k], pick[t]} = {pick[t], pick[k]};
			t = $urandom_range(0, k);
			{order[k], order[t]} = {order[t], order[k]};
		end
		if ($urandom_range(0, 5) == 0) pick[$urandom_range(0, n - 1)] = pick[0];
		for (k = 0; k < n; k++) begin
			if ($urandom_range(0, 15) == 0)
				send_beat(MODE_RANK, 4'($urandom), 4'($urandom_range(n, 15)), 1'($urandom));
			send_beat(MODE_RANK, 4'(order[k]), pick[order[k]], k == n - 1);
		end
	endtask

	task automatic random_phase(logic [3:0] c, int items, bit pause_mid);
		int n, stop;
		n = field_count(c);
		set_count(c);
		no_gaps = ($urandom_range(0, 3) == 0);
		stop = beats_sent + items;
		while (beats_sent < stop) begin
			if (pause_mid && beats_sent > stop - items / 2) begin
				drain();
				pause_mid = 1'b0;
				no_gaps = !no_gaps;
			end
			case ($urandom_range(0, 19))
				0, 1: send_beat(MODE_DECIDE, 4'($urandom), 4'($urandom), 1'($urandom));
				2: if (n < 7 || $urandom_range(0, 2) == 0)
					send_beat(MODE_DECIDE, 4'($urandom), 4'($urandom), 1'($urandom));
				3: if ($urandom_range(0, 2) == 0)
					send_beat(MODE_CLEAR, 4'($urandom), 4'($urandom), 1'($urandom));
				4, 5: send_beat(2'($urandom), 4'($urandom), 4'($urandom), 1'($urandom));
				default: cast_ballot(n);
			endcase
		end
	endtask

	initial begin
		logic [3:0] sweep[10];
		sweep = '{4'd2, 4'd0, 4'd5, 4'd15, 4'd1, 4'd3, 4'd9, 4'd12, 4'd4, 4'd7};
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		no_gaps = 1'b0;
		beats_sent = 0;
		settings_run = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: fill every buffer slot first, then the corner cases.
		set_count(4'd9);
		for (int p = 0; p < MaxCand; p++)
			send_beat(MODE_RANK, 4'(p), 4'(8 - p), p == MaxCand - 1);
		send_beat(MODE_RANK, 4'd0, 4'd15, 1'b1);
		send_beat(MODE_RANK, 4'd15, 4'd0, 1'b1);
		send_beat(2'd3, 4'd15, 4'd15, 1'b1);
		send_beat(MODE_DECIDE, 4'd0, 4'd0, 1'b0);
		send_beat(MODE_DECIDE, 4'd0, 4'd0, 1'b0);
		send_beat(MODE_CLEAR, 4'd0, 4'd0, 1'b0);
		send_beat(MODE_DECIDE, 4'd0, 4'd0, 1'b0);
		// rotated rankings form a majority cycle
		for (int r = 0; r < 3; r++)
			for (int p = 0; p < MaxCand; p++)
				send_beat(MODE_RANK, 4'(p), 4'((p + 3 * r) % MaxCand), p == MaxCand - 1);
		send_beat(MODE_DECIDE, 4'd0, 4'd0, 1'b0);
		// a repeated candidate ballot
		for (int p = 0; p < MaxCand; p++)
			send_beat(MODE_RANK, 4'(p), 4'd4, p == MaxCand - 1);
		send_beat(MODE_DECIDE, 4'd0, 4'd0, 1'b0);

		foreach (sweep[k]) random_phase(sweep[k], 78, k == 2);
		s_tvalid <= 1'b0;
		@(posedge clk);
		drain();
		$display("covered %0d beats in, %0d results out over %0d candidate counts",
			beats_sent, results, settings_run);
		if (failures == 0) begin
			$display("[ranked_pairs_election_core] OK");
		end else begin
			$display("[ranked_pairs_election_core] ERROR");
		end
		$finish;
	end
endmodule
